>>> rtl/core/chd_pkg.sv
// Shared types and constants for the compass heading tracker.
// Holds the command and status structs between controller and datapath,
// and the arctangent table. No dependencies.
package chd_pkg;

  // Default parameter values
  localparam int CHD_FRAC_BITS_DEF    = 8;
  localparam int CHD_CORDIC_STEPS_DEF = 16;

  // Field widths
  localparam int CHD_SAMPLE_W = 16;
  localparam int CHD_GAIN_W   = 9;
  localparam int CHD_DEG_W    = 9;

  // Reset value of the smoothing gain (about 0.2 in 256ths)
  localparam logic [CHD_GAIN_W-1:0] CHD_GAIN_RST  = 9'd51;
  localparam logic [CHD_GAIN_W-1:0] CHD_GAIN_FULL = 9'd256;

  // Angle accumulator: degrees with 16 fraction bits, signed
  localparam int CHD_DEG_FRAC = 16;
  localparam int CHD_ZW       = 27;
  localparam logic signed [CHD_ZW-1:0] CHD_Z_HALF = 27'sd11796480;  // 180 deg
  localparam logic signed [CHD_ZW-1:0] CHD_Z_FULL = 27'sd23592960;  // 360 deg

  // Whole degree constants
  localparam logic [CHD_DEG_W-1:0] CHD_DEG_0   = 9'd0;
  localparam logic [CHD_DEG_W-1:0] CHD_DEG_90  = 9'd90;
  localparam logic [CHD_DEG_W-1:0] CHD_DEG_180 = 9'd180;
  localparam logic [CHD_DEG_W-1:0] CHD_DEG_270 = 9'd270;
  localparam logic [CHD_DEG_W-1:0] CHD_DEG_359 = 9'd359;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
  localparam int CHD_TAB_DEPTH = 24;
  localparam int CHD_IDX_W     = 5;
  localparam int CHD_ATAN_VAL [CHD_TAB_DEPTH] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // capture the input request
    logic filt_mul;     // register the filter products
    logic filt_upd;     // update the filter state
    logic cordic_init;  // set up the rotation and special cases
    logic cordic_step;  // one rotation step
    logic wrap;         // wrap the angle, store current or target heading
    logic out_load;     // load the result register
  } chd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic step_last;    // the step being done is the final rotation
  } chd_stat_t;

endpackage

>>> rtl/core/chd_ctrl.sv
// Controller for the compass heading tracker: sequences one request through
// filtering, CORDIC rotation and result load. Uses chd_pkg.
module chd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  chd_pkg::chd_stat_t  stat,
  output chd_pkg::chd_cmd_t   cmd
);
  import chd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_INIT = 7'b0001000,
    S_STEP = 7'b0010000,
    S_WRAP = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // Result register can take a new value this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_INIT;
      S_INIT: state_nxt = S_STEP;
      S_STEP: if (stat.step_last) state_nxt = S_WRAP;
      S_WRAP: state_nxt = S_DONE;
      S_DONE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd             = '0;
    cmd.load        = (state_r == S_IDLE) && in_valid;
    cmd.filt_mul    = (state_r == S_MUL);
    cmd.filt_upd    = (state_r == S_UPD);
    cmd.cordic_init = (state_r == S_INIT);
    cmd.cordic_step = (state_r == S_STEP);
    cmd.wrap        = (state_r == S_WRAP);
    cmd.out_load    = (state_r == S_DONE) && slot_free;
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)
      out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/chd_dpath.sv
// Datapath for the compass heading tracker: low-pass filters, shared CORDIC
// shift-add unit, heading registers and result register. Uses chd_pkg.
module chd_dpath #(
  parameter int FRAC_BITS    = chd_pkg::CHD_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = chd_pkg::CHD_CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [chd_pkg::CHD_GAIN_W-1:0]         cfg_wdata,
  input  logic                                   in_cmd,
  input  logic signed [chd_pkg::CHD_SAMPLE_W-1:0] in_mag_x,
  input  logic signed [chd_pkg::CHD_SAMPLE_W-1:0] in_mag_y,
  output logic [chd_pkg::CHD_DEG_W-1:0]          out_heading_deg,
  output logic signed [chd_pkg::CHD_DEG_W-1:0]   out_heading_error,
  input  chd_pkg::chd_cmd_t                      cmd,
  output chd_pkg::chd_stat_t                     stat
);
  import chd_pkg::*;

  localparam int FW = CHD_SAMPLE_W + FRAC_BITS;  // filter state width
  localparam int CW = FW + 3;                    // CORDIC width, gain headroom
  localparam int PW = FW + 11;                   // filter product width

  // Registers
  logic [CHD_GAIN_W-1:0]         gain_r;
  logic                          cmd_r;
  logic signed [CHD_SAMPLE_W-1:0] samp_x_r, samp_y_r;
  logic signed [FW-1:0]          filt_x_r, filt_y_r;
  logic signed [PW-1:0]          prod_x_r, prod_y_r;
  logic signed [CW-1:0]          cx_r, cy_r;
  logic signed [CHD_ZW-1:0]      z_r;
  logic [CHD_IDX_W-1:0]          cnt_r;
  logic                          spec_r;
  logic [CHD_DEG_W-1:0]          spec_deg_r;
  logic [CHD_DEG_W-1:0]          cur_r, tgt_r, head_r;
  logic [CHD_DEG_W-1:0]          res_deg_r;
  logic signed [CHD_DEG_W-1:0]   res_err_r;

  // Combinational values
  logic [CHD_GAIN_W-1:0]         gain_eff;
  logic signed [FW:0]            diff_x, diff_y;
  logic signed [PW-1:0]          prod_x, prod_y;
  logic signed [PW-1:0]          sh_x, sh_y;
  logic signed [CW-1:0]          fx_ext, fy_ext;
  logic signed [CW-1:0]          dx, dy;
  logic                          y_pos;
  logic signed [CHD_ZW-1:0]      atan_i;
  logic signed [CHD_ZW-1:0]      z_wrap;
  logic [CHD_ZW-CHD_DEG_FRAC-1:0] deg_full;
  logic [CHD_DEG_W-1:0]          head_nxt;
  logic                          spec_nxt;
  logic [CHD_DEG_W-1:0]          spec_deg_nxt;
  logic signed [CHD_DEG_W:0]     err_raw;
  logic signed [CHD_DEG_W:0]     err_adj;
  logic signed [CHD_DEG_W-1:0]   err_nxt;

  // Gain above 256 acts as 256
  assign gain_eff = gain_r[CHD_GAIN_W-1] ? CHD_GAIN_FULL : gain_r;

  // Filter: product of gain and (scaled sample - state)
  assign diff_x = $signed({samp_x_r[CHD_SAMPLE_W-1], samp_x_r, {FRAC_BITS{1'b0}}})
                - $signed({filt_x_r[FW-1], filt_x_r});
  assign diff_y = $signed({samp_y_r[CHD_SAMPLE_W-1], samp_y_r, {FRAC_BITS{1'b0}}})
                - $signed({filt_y_r[FW-1], filt_y_r});
  assign prod_x = $signed({1'b0, gain_eff}) * diff_x;
  assign prod_y = $signed({1'b0, gain_eff}) * diff_y;
  assign sh_x   = prod_x_r >>> 8;
  assign sh_y   = prod_y_r >>> 8;

  // CORDIC operands
  assign fx_ext = CW'(filt_x_r);
  assign fy_ext = CW'(filt_y_r);
  assign dx     = cy_r >>> cnt_r;
  assign dy     = cx_r >>> cnt_r;
  assign y_pos  = !cy_r[CW-1] && (cy_r != '0);
  assign atan_i = CHD_ZW'(CHD_ATAN_VAL[cnt_r]);

  // Special cases: zero vector and vectors on an axis
  always_comb begin
    spec_nxt     = 1'b1;
    spec_deg_nxt = CHD_DEG_0;
    if (filt_x_r == '0 && filt_y_r == '0)
      spec_deg_nxt = CHD_DEG_0;
    else if (filt_y_r == '0)
      spec_deg_nxt = filt_x_r[FW-1] ? CHD_DEG_180 : CHD_DEG_0;
    else if (filt_x_r == '0)
      spec_deg_nxt = filt_y_r[FW-1] ? CHD_DEG_270 : CHD_DEG_90;
    else
      spec_nxt = 1'b0;
  end

  // Wrap the angle into one turn, take whole degrees
  always_comb begin
    z_wrap = z_r;
    if (z_r[CHD_ZW-1])
      z_wrap = z_r + CHD_Z_FULL;
    else if (z_r >= CHD_Z_FULL)
      z_wrap = z_r - CHD_Z_FULL;
    deg_full = z_wrap[CHD_ZW-1:CHD_DEG_FRAC];
    if (spec_r)
      head_nxt = spec_deg_r;
    else if (deg_full > (CHD_ZW-CHD_DEG_FRAC)'(CHD_DEG_359))
      head_nxt = CHD_DEG_359;
    else
      head_nxt = deg_full[CHD_DEG_W-1:0];
  end

  // Target minus current, wrapped, with the half-turn flip
  always_comb begin
    err_raw = $signed({1'b0, tgt_r}) - $signed({1'b0, cur_r});
    err_adj = err_raw;
    if (err_raw > 10'sd180)
      err_adj = err_raw - 10'sd360;
    else if (err_raw < -10'sd180)
      err_adj = err_raw + 10'sd360;
    if (err_adj == 10'sd180)
      err_adj = -10'sd180;
    else if (err_adj == -10'sd180)
      err_adj = 10'sd180;
    err_nxt = err_adj[CHD_DEG_W-1:0];
  end

  // Control-visible state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= CHD_GAIN_RST;
      filt_x_r <= '0;
      filt_y_r <= '0;
      cur_r    <= '0;
      tgt_r    <= '0;
    end else begin
      if (cfg_we)
        gain_r <= cfg_wdata;
      if (cmd.filt_upd) begin
        filt_x_r <= filt_x_r + sh_x[FW-1:0];
        filt_y_r <= filt_y_r + sh_y[FW-1:0];
      end
      if (cmd.wrap) begin
        if (cmd_r)
          tgt_r <= head_nxt;
        else
          cur_r <= head_nxt;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      samp_x_r <= in_mag_x;
      samp_y_r <= in_mag_y;
    end
    if (cmd.filt_mul) begin
      prod_x_r <= prod_x;
      prod_y_r <= prod_y;
    end
    if (cmd.cordic_init) begin
      cnt_r      <= '0;
      spec_r     <= spec_nxt;
      spec_deg_r <= spec_deg_nxt;
      if (filt_x_r[FW-1]) begin
        cx_r <= -fx_ext;
        cy_r <= -fy_ext;
        z_r  <= CHD_Z_HALF;
      end else begin
        cx_r <= fx_ext;
        cy_r <= fy_ext;
        z_r  <= '0;
      end
    end
    if (cmd.cordic_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (y_pos) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + atan_i;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - atan_i;
      end
    end
    if (cmd.wrap)
      head_r <= head_nxt;
    if (cmd.out_load) begin
      res_deg_r <= head_r;
      res_err_r <= err_nxt;
    end
  end

  assign stat.step_last   = (cnt_r == CHD_IDX_W'(CORDIC_STEPS - 1));
  assign out_heading_deg   = res_deg_r;
  assign out_heading_error = res_err_r;

endmodule

>>> rtl/core/compass_heading_tracker.sv
// Top level of the compass heading tracker: joins the controller and the
// datapath. Uses chd_pkg, chd_ctrl and chd_dpath.
//
//   port group  direction  contents
//   in_         request    cmd, mag_x, mag_y     (valid / stall)
//   out_        result     heading_deg, heading_error (valid / stall)
//   cfg_        write      smoothing gain, 9 bits (write enable, no read-back)
//
// From acceptance to the result register a request passes the filter multiply,
// filter update, CORDIC set-up, the CORDIC loop and the wrap; the loop runs one
// rotation per cycle through a single shift-add unit.
// Reset clears the filters and both headings and loads a gain of 51.
// A held result stalls only the final load; the next request is taken while
// an earlier result waits on out_stall.
module compass_heading_tracker #(
  parameter int FRAC_BITS    = chd_pkg::CHD_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = chd_pkg::CHD_CORDIC_STEPS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [chd_pkg::CHD_GAIN_W-1:0]          cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_cmd,
  input  logic signed [chd_pkg::CHD_SAMPLE_W-1:0] in_mag_x,
  input  logic signed [chd_pkg::CHD_SAMPLE_W-1:0] in_mag_y,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [chd_pkg::CHD_DEG_W-1:0]           out_heading_deg,
  output logic signed [chd_pkg::CHD_DEG_W-1:0]    out_heading_error
);
  import chd_pkg::*;

  chd_cmd_t  cmd;
  chd_stat_t stat;

  chd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  chd_dpath #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_mag_x          (in_mag_x),
    .in_mag_y          (in_mag_y),
    .out_heading_deg   (out_heading_deg),
    .out_heading_error (out_heading_error),
    .cmd               (cmd),
    .stat              (stat)
  );

  // Busy straight after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while not idle next cycle");

  // Result heading within one turn
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_deg <= CHD_DEG_359))
    else $error("heading out of range");

  // Heading error within a half turn either way
  a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_heading_error <= 9'sd180) && (out_heading_error >= -9'sd180)))
    else $error("heading error out of range");

  // A new result is loaded only while idle of requests, never mid-accept
  a_load_not_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |-> $past(in_stall))
    else $error("result loaded while a request could be taken");

endmodule

>>> tb/sv/compass_heading_tracker_tb.sv
// Testbench for compass_heading_tracker: directed and random magnetometer requests,
// checked against an in-bench predictor of the filters, CORDIC heading and error.
// Depends on chd_pkg and the compass_heading_tracker RTL only.
`timescale 1ns / 1ps

module compass_heading_tracker_tb;
  import chd_pkg::*;

  localparam int FRAC         = CHD_FRAC_BITS_DEF;
  localparam int STEPS        = CHD_CORDIC_STEPS_DEF;
  localparam int SETTLE_CYCLES = 32;       // settle time after draining, with margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1350;

  typedef struct {
    logic [CHD_DEG_W-1:0]        hdg;
    logic signed [CHD_DEG_W-1:0] err;
  } heading_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [CHD_GAIN_W-1:0]          cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_cmd = 1'b0;
  logic signed [CHD_SAMPLE_W-1:0] in_mag_x = '0;
  logic signed [CHD_SAMPLE_W-1:0] in_mag_y = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [CHD_DEG_W-1:0]           out_heading_deg;
  logic signed [CHD_DEG_W-1:0]    out_heading_error;

  // Predictor state, mirrors the block after reset
  longint                filt_x = 0;
  longint                filt_y = 0;
  logic [CHD_DEG_W-1:0]  cur_hdg = '0;
  logic [CHD_DEG_W-1:0]  tgt_hdg = '0;
  logic [CHD_GAIN_W-1:0] gain_reg = CHD_GAIN_RST;

  heading_result_t expected_headings[$];
  int              mismatches = 0;
  int              cycle_count = 0;
  int              burst_left = 0;
  int              stall_left = 0;
  int              stall_mode = 0;
  int              stall_phase = 0;

  compass_heading_tracker #(
    .FRAC_BITS   (FRAC),
    .CORDIC_STEPS(STEPS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_mag_x         (in_mag_x),
    .in_mag_y         (in_mag_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_heading_deg  (out_heading_deg),
    .out_heading_error(out_heading_error)
  );

  always #6 clk = ~clk;

  // Heading of a filtered vector: axis shortcuts, else fold into the right
  // half plane and run the shift-add rotation on a degree accumulator
  function automatic logic [CHD_DEG_W-1:0] cordic_heading(input longint x, input longint y);
    longint z;
    longint dx;
    longint dy;
    longint deg;
    int     i;
    z = 0;
    if (x == 0 && y == 0) return CHD_DEG_0;
    if (y == 0) return (x > 0) ? CHD_DEG_0 : CHD_DEG_180;
    if (x == 0) return (y > 0) ? CHD_DEG_90 : CHD_DEG_270;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(CHD_Z_HALF);
    end
    for (i = 0; i < STEPS && i < CHD_TAB_DEPTH; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + CHD_ATAN_VAL[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - CHD_ATAN_VAL[i];
      end
    end
    while (z < 0) z = z + longint'(CHD_Z_FULL);
    while (z >= longint'(CHD_Z_FULL)) z = z - longint'(CHD_Z_FULL);
    deg = z / (longint'(1) << CHD_DEG_FRAC);
    if (deg > 359) return CHD_DEG_359;
    return deg[CHD_DEG_W-1:0];
  endfunction

  // Advance the filters with one accepted request and queue its expected result
  task automatic track_sample(input logic c, input logic signed [CHD_SAMPLE_W-1:0] x,
                              input logic signed [CHD_SAMPLE_W-1:0] y);
    heading_result_t r;
    longint          g;
    int              diff;
    g = (gain_reg > CHD_GAIN_FULL) ? longint'(CHD_GAIN_FULL) : longint'(gain_reg);
    filt_x = filt_x + ((g * ((longint'(x) <<< FRAC) - filt_x)) >>> 8);
    filt_y = filt_y + ((g * ((longint'(y) <<< FRAC) - filt_y)) >>> 8);
    r.hdg = cordic_heading(filt_x, filt_y);
    if (c) tgt_hdg = r.hdg;
    else cur_hdg = r.hdg;
    diff = int'(tgt_hdg) - int'(cur_hdg);
    if (diff > 180) diff = diff - 360;
    else if (diff < -180) diff = diff + 360;
    // an exact half turn flips sign
    if (diff == 180) diff = -180;
    else if (diff == -180) diff = 180;
    r.err = diff[CHD_DEG_W-1:0];
    expected_headings.push_back(r);
  endtask

  // Send one request with bursty pacing; returns at the accepting edge
  task automatic send_request(input logic c, input logic signed [CHD_SAMPLE_W-1:0] x,
                              input logic signed [CHD_SAMPLE_W-1:0] y);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_mag_x <= x;
    in_mag_y <= y;
    do @(posedge clk); while (in_stall);
    track_sample(c, x, y);
  endtask

  // Hold off the sender until every result is back and the block has gone quiet
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_headings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CHD_GAIN_W-1:0] g);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gain_reg = g;
  endtask

  function automatic logic signed [CHD_SAMPLE_W-1:0] sat_sample(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CHD_SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [CHD_SAMPLE_W-1:0] extreme_sample();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // Reset gain of 51 is in force for the first requests
  task automatic test_reset_state();
    send_request(1'b0, 16'sd0, 16'sd0);
    send_request(1'b1, 16'sh7fff, 16'sh7fff);
  endtask

  // Full gain: filter follows the sample, so axis vectors give exact headings
  task automatic test_axis_headings();
    write_gain(CHD_GAIN_FULL);
    send_request(1'b0, 16'sh7fff, 16'sd0);
    send_request(1'b1, 16'sd0, 16'sh7fff);
    send_request(1'b0, 16'sh8000, 16'sd0);
    send_request(1'b1, 16'sd0, 16'sh8000);
    send_request(1'b0, 16'sd0, 16'sd0);
    send_request(1'b1, -16'sd1, -16'sd1);
    send_request(1'b0, 16'sd1, 16'sh8000);
    send_request(1'b1, 16'sh8000, 16'sh7fff);
  endtask

  // Target minus current at exactly plus and minus a half turn, and past it
  task automatic test_half_turn_error();
    send_request(1'b0, 16'sh7fff, 16'sd0);
    send_request(1'b1, 16'sh8000, 16'sd0);
    send_request(1'b0, 16'sh8000, 16'sd0);
    send_request(1'b1, 16'sh7fff, 16'sd0);
    send_request(1'b0, 16'sd1000, 16'sd180);
    send_request(1'b1, 16'sd0, 16'sh8000);
  endtask

  // Gains above full scale clip to full; zero freezes the filter
  task automatic test_gain_extremes();
    write_gain(9'd511);
    send_request(1'b0, 16'sh8000, 16'sh8000);
    write_gain(9'd257);
    send_request(1'b1, 16'sh7fff, 16'sh8000);
    write_gain(9'd0);
    send_request(1'b0, 16'sh7fff, 16'sh7fff);
    send_request(1'b1, 16'sh8000, 16'sd5);
    write_gain(9'd1);
    send_request(1'b0, 16'sh7fff, 16'sh7fff);
    send_request(1'b1, 16'sh8000, 16'sh8000);
  endtask

  // Settling runs around a random bearing, mixed with noise and extreme samples,
  // over a sweep of gains
  task automatic test_random_tracking();
    logic [CHD_GAIN_W-1:0]          gains[9];
    int                             n_phase;
    int                             sent;
    int                             run_len;
    int                             noise;
    int                             p;
    logic                           c;
    logic signed [CHD_SAMPLE_W-1:0] bx;
    logic signed [CHD_SAMPLE_W-1:0] by;
    gains = '{9'd51, 9'd128, 9'd255, CHD_GAIN_FULL, 9'd1, 9'd511, 9'd0, 9'd257, 9'd200};
    for (p = 0; p < 9; p++) begin
      write_gain(gains[p]);
      n_phase = (gains[p] == 0) ? 40 : (RANDOM_ITEMS - 40) / 8;
      sent = 0;
      while (sent < n_phase) begin
        case ($urandom_range(0, 9))
          7, 8: begin
            send_request(1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 16'hffff)),
                         16'($urandom_range(0, 16'hffff)));
            sent++;
          end
          9: begin
            send_request(1'($urandom_range(0, 1)), extreme_sample(), extreme_sample());
            sent++;
          end
          default: begin
            // repeated samples around one bearing, as software does to settle
            bx = $signed(16'($urandom_range(0, 16'hffff))) >>> $urandom_range(0, 12);
            by = $signed(16'($urandom_range(0, 16'hffff))) >>> $urandom_range(0, 12);
            c = 1'($urandom_range(0, 1));
            run_len = $urandom_range(2, 12);
            noise = $urandom_range(0, 64);
            repeat (run_len) begin
              send_request(c,
                sat_sample(longint'(bx) + longint'($urandom_range(0, 2 * noise)) - noise),
                sat_sample(longint'(by) + longint'($urandom_range(0, 2 * noise)) - noise));
              sent++;
            end
          end
        endcase
        if (p == 4 && sent >= n_phase / 2 && sent < n_phase / 2 + 12) wait_results_drained();
      end
    end
  endtask

  // Receiver stall: picks a new random pattern whenever its run counter runs out
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ((stall_phase % 5) < 2);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic note_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  // Compare each delivered result with the oldest expectation
  always @(posedge clk) begin : check_results
    heading_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_headings.size() == 0) begin
        note_mismatch("result with none pending, heading_deg", -1, out_heading_deg);
      end else begin
        want = expected_headings.pop_front();
        if (out_heading_deg !== want.hdg)
          note_mismatch("heading_deg", want.hdg, out_heading_deg);
        if (out_heading_error !== want.err)
          note_mismatch("heading_error", want.err, out_heading_error);
      end
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_axis_headings();
    test_half_turn_error();
    test_gain_extremes();
    test_random_tracking();
    wait_results_drained();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
